// ===== rtl/core/eaptls_pkg.sv =====
// ----------------------------------------------------------------------------
// EAP-TLS fragment tracker package
// Shared codes, sizes and the classified item type passed front to back.
// ----------------------------------------------------------------------------
package eaptls_pkg;

    // Fragment payload size for outgoing messages
    localparam logic [15:0] FRAG_SIZE = 16'd1024;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation codes
    localparam logic [2:0] OP_RECV      = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_BUILD     = 3'd2;
    localparam logic [2:0] OP_CLR_RECV  = 3'd3;
    localparam logic [2:0] OP_CLR_SEND  = 3'd4;

    // EAP-TLS flag bits
    localparam logic [7:0] FLAG_START = 8'h20;
    localparam logic [7:0] FLAG_MORE  = 8'h40;
    localparam logic [7:0] FLAG_LEN   = 8'h80;
    localparam logic [7:0] NO_FLAGS   = 8'hff;
    localparam logic [7:0] FLAGS_NONE = 8'h00;

    // Header overheads in bytes
    localparam logic [15:0] LEN_FIELD_BYTES = 16'd4;
    localparam logic [15:0] EAP_BASE_LEN    = 16'd4;
    localparam logic [15:0] MIN_LEN_FRAME   = 16'd5;

    typedef enum logic [2:0] {
        ST_CONTINUE   = 3'd0,
        ST_START      = 3'd1,
        ST_MORE       = 3'd2,
        ST_SEND_DONE  = 3'd3,
        ST_RECV_DONE  = 3'd4,
        ST_FAIL       = 3'd5,
        ST_DECODE_ERR = 3'd6,
        ST_OK         = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        K_RECV,
        K_LOAD,
        K_BUILD,
        K_CLR_RECV,
        K_CLR_SEND,
        K_BAD
    } t_kind;

    // Classified item
    typedef struct packed {
        t_kind       kind;
        logic        flen_zero;  // empty frame
        logic        is_start;   // Start flag set
        logic        is_more;    // More flag set
        logic        is_ack;     // flags exactly none or Length only
        logic        len_used;   // a 4-byte length field is counted (Length with More, or Length only)
        logic        len_short;  // length field present but frame too short
        logic [15:0] pay_len;    // TLS data bytes in the received frame
        logic [15:0] declared;   // low half of declared total length
        logic        newseq;
        logic [7:0]  flags;
        logic [15:0] mlen;
    } t_item;

endpackage

// ===== rtl/core/eaptls_front.sv =====
// ----------------------------------------------------------------------------
// EAP-TLS front end
// Accepts requests, decodes the op and classifies the received header.
// ----------------------------------------------------------------------------
module eaptls_front
    import eaptls_pkg::*;
(
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_flags_byte,
    input  logic [15:0] i_frame_length,
    input  logic [31:0] i_length_field,
    input  logic        i_new_sequence,
    input  logic [15:0] i_message_length,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic        len_used;
    logic [15:0] hdr_bytes;

    // Accept whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Length field counts only on More fragments or a plain Length header
    assign len_used  = ((i_flags_byte & FLAG_LEN) != '0) &&
                       (((i_flags_byte & FLAG_MORE) != '0) || (i_flags_byte == FLAG_LEN));
    assign hdr_bytes = len_used ? (LEN_FIELD_BYTES + 16'd1) : 16'd1;

    // Classify the request
    always_comb begin
        o_item = '0;
        case (i_op)
            OP_RECV:     o_item.kind = K_RECV;
            OP_LOAD:     o_item.kind = K_LOAD;
            OP_BUILD:    o_item.kind = K_BUILD;
            OP_CLR_RECV: o_item.kind = K_CLR_RECV;
            OP_CLR_SEND: o_item.kind = K_CLR_SEND;
            default:     o_item.kind = K_BAD;
        endcase
        o_item.flen_zero = (i_frame_length == '0);
        o_item.is_start  = (i_flags_byte & FLAG_START) != '0;
        o_item.is_more   = (i_flags_byte & FLAG_MORE) != '0;
        o_item.is_ack    = (i_flags_byte == FLAGS_NONE) || (i_flags_byte == FLAG_LEN);
        o_item.len_used  = len_used;
        o_item.len_short = len_used && (i_frame_length < MIN_LEN_FRAME);
        o_item.pay_len   = i_frame_length - hdr_bytes;
        o_item.declared  = i_length_field[15:0];
        o_item.newseq    = i_new_sequence;
        o_item.flags     = i_flags_byte;
        o_item.mlen      = i_message_length;
    end

endmodule

// ===== rtl/core/eaptls_queue.sv =====
// ----------------------------------------------------------------------------
// EAP-TLS item queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module eaptls_queue
    import eaptls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/eaptls_back.sv =====
// ----------------------------------------------------------------------------
// EAP-TLS back end
// Holds the send and receive counters, executes items, registers results.
// ----------------------------------------------------------------------------
module eaptls_back
    import eaptls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_flags,
    output logic        o_flags_present,
    output logic        o_length_present,
    output logic [15:0] o_fragment_bytes,
    output logic [15:0] o_eap_length
);

    // Counter state
    logic [15:0] r_send_total, n_send_total;
    logic [15:0] r_send_done,  n_send_done;
    logic        r_send_active, n_send_active;
    logic [15:0] r_recv_total, n_recv_total;
    logic [15:0] r_recv_done,  n_recv_done;
    logic        r_recv_active, n_recv_active;

    // Result register
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [7:0]  r_oflags, n_oflags;
    logic        r_fpres, n_fpres;
    logic        r_lpres, n_lpres;
    logic [15:0] r_fbytes, n_fbytes;
    logic [15:0] r_elen, n_elen;

    logic        step;

    // Take an item when the result slot is free or being drained
    assign step  = !i_q_empty && (!r_out_valid || i_ready);
    assign o_pop = step;

    // Execute one item
    always_comb begin
        t_status     res;
        logic        go_on;
        logic [16:0] ack_sum;
        logic [16:0] rx_sum;
        logic [15:0] remaining;
        logic [16:0] elen_w;

        n_send_total  = r_send_total;
        n_send_done   = r_send_done;
        n_send_active = r_send_active;
        n_recv_total  = r_recv_total;
        n_recv_done   = r_recv_done;
        n_recv_active = r_recv_active;
        n_status      = ST_OK;
        n_oflags      = '0;
        n_fpres       = 1'b0;
        n_lpres       = 1'b0;
        n_fbytes      = '0;
        n_elen        = EAP_BASE_LEN;
        res           = ST_CONTINUE;
        go_on         = 1'b1;
        ack_sum       = {1'b0, r_send_done} + {1'b0, FRAG_SIZE};
        rx_sum        = '0;
        remaining     = '0;
        elen_w        = '0;

        case (i_item.kind)
            K_RECV: begin
                if (i_item.flen_zero) begin
                    n_status = ST_DECODE_ERR;
                end else if (i_item.is_start) begin
                    n_status = ST_START;
                end else begin
                    if (i_item.is_more) begin
                        // Peer is fragmenting: reset send side
                        n_send_total  = '0;
                        n_send_done   = '0;
                        n_send_active = 1'b1;
                        if (i_item.len_short) begin
                            go_on = 1'b0;
                        end else if (i_item.len_used && !r_recv_active) begin
                            n_recv_total  = i_item.declared;
                            n_recv_done   = '0;
                            n_recv_active = 1'b1;
                        end
                        res = ST_MORE;
                    end else if (i_item.is_ack) begin
                        if (i_item.len_short) begin
                            go_on = 1'b0;
                        end else if (i_item.newseq && r_send_active &&
                                     (r_send_total != '0)) begin
                            // Acknowledge one outgoing fragment
                            if (ack_sum < {1'b0, r_send_total}) begin
                                n_send_done = ack_sum[15:0];
                            end else begin
                                n_send_total  = '0;
                                n_send_done   = '0;
                                n_send_active = 1'b1;
                                res           = ST_SEND_DONE;
                            end
                        end
                    end
                    if (!go_on) begin
                        n_status = ST_DECODE_ERR;
                    end else if (i_item.pay_len == '0) begin
                        n_status = (i_item.newseq && res == ST_CONTINUE) ? ST_FAIL : res;
                    end else begin
                        if (i_item.newseq) begin
                            // Count received data
                            if (!n_recv_active) begin
                                n_recv_total  = i_item.pay_len;
                                n_recv_done   = '0;
                                n_recv_active = 1'b1;
                            end
                            rx_sum = {1'b0, n_recv_done} + {1'b0, i_item.pay_len};
                            if (rx_sum > {1'b0, n_recv_total}) begin
                                res = ST_RECV_DONE;
                            end else begin
                                n_recv_done = rx_sum[15:0];
                                if (rx_sum[15:0] == n_recv_total) begin
                                    res = ST_RECV_DONE;
                                end
                            end
                        end
                        n_status = res;
                    end
                end
            end
            K_LOAD: begin
                n_send_total  = i_item.mlen;
                n_send_done   = '0;
                n_send_active = 1'b1;
            end
            K_BUILD: begin
                n_oflags = i_item.flags;
                if (r_send_active) begin
                    n_fpres   = (i_item.flags != NO_FLAGS);
                    remaining = (r_send_total > r_send_done) ?
                                (r_send_total - r_send_done) : '0;
                    if (remaining > FRAG_SIZE) begin
                        n_fbytes = FRAG_SIZE;
                        if (r_send_done == '0) begin
                            n_lpres  = 1'b1;
                            n_oflags = i_item.flags | FLAG_MORE | FLAG_LEN;
                        end else begin
                            n_oflags = i_item.flags | FLAG_MORE;
                        end
                    end else begin
                        n_fbytes = remaining;
                    end
                    elen_w = {1'b0, EAP_BASE_LEN} + {16'd0, n_fpres} + {1'b0, n_fbytes}
                           + (n_lpres ? {1'b0, LEN_FIELD_BYTES} : 17'd0);
                    n_elen = elen_w[15:0];
                end
            end
            K_CLR_RECV: begin
                n_recv_total  = '0;
                n_recv_done   = '0;
                n_recv_active = 1'b0;
            end
            K_CLR_SEND: begin
                n_send_total  = '0;
                n_send_done   = '0;
                n_send_active = 1'b0;
            end
            default: begin
                n_status = ST_DECODE_ERR;
            end
        endcase
    end

    // Commit state and valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_total  <= '0;
            r_send_done   <= '0;
            r_send_active <= 1'b0;
            r_recv_total  <= '0;
            r_recv_done   <= '0;
            r_recv_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (step) begin
                r_send_total  <= n_send_total;
                r_send_done   <= n_send_done;
                r_send_active <= n_send_active;
                r_recv_total  <= n_recv_total;
                r_recv_done   <= n_recv_done;
                r_recv_active <= n_recv_active;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status <= n_status;
            r_oflags <= n_oflags;
            r_fpres  <= n_fpres;
            r_lpres  <= n_lpres;
            r_fbytes <= n_fbytes;
            r_elen   <= n_elen;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_out_flags      = r_oflags;
    assign o_flags_present  = r_fpres;
    assign o_length_present = r_lpres;
    assign o_fragment_bytes = r_fbytes;
    assign o_eap_length     = r_elen;

endmodule

// ===== rtl/core/eap_tls_fragment_tracker.sv =====
// An input passes through the queue, then the result register, before its result is offered.
// Throughput: one request per cycle while the queue has room and the result side drains.
// The two-entry queue lets the front keep accepting while a result waits; once it fills,
// input ready returns in the cycle after the result side drains.
// Reset: synchronous active low; clears all counters, the queue and the result valid.
// ----------------------------------------------------------------------------
// EAP-TLS fragment tracker
// Classifies EAP-TLS headers and tracks send and receive fragmentation.
// ----------------------------------------------------------------------------
module eap_tls_fragment_tracker
    import eaptls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_flags_byte,
    input  logic [15:0] i_frame_length,
    input  logic [31:0] i_length_field,
    input  logic        i_new_sequence,
    input  logic [15:0] i_message_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_flags,
    output logic        o_flags_present,
    output logic        o_length_present,
    output logic [15:0] o_fragment_bytes,
    output logic [15:0] o_eap_length
);

    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    // Classify incoming requests
    eaptls_front u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_flags_byte     (i_flags_byte),
        .i_frame_length   (i_frame_length),
        .i_length_field   (i_length_field),
        .i_new_sequence   (i_new_sequence),
        .i_message_length (i_message_length),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (front_item)
    );

    // Buffer classified items
    eaptls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (queue_item)
    );

    // Execute against the counters
    eaptls_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_item           (queue_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_flags      (o_out_flags),
        .o_flags_present  (o_flags_present),
        .o_length_present (o_length_present),
        .o_fragment_bytes (o_fragment_bytes),
        .o_eap_length     (o_eap_length)
    );

endmodule
